/* rtl/core/ouvs_pkg.sv */
// Package with the types, sizes and operation codes of the ordered unique value set.
package ouvs_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] value;
  } ouvs_req_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic               rejected_full;
  } ouvs_rsp_t;

  typedef struct packed {
    logic valid;
    logic load;
    logic shift;
  } ouvs_cell_ctl_t;

endpackage

/* rtl/core/ouvs_cell.sv */
// One storage cell of the value chain: holds an entry, compares it and takes its neighbor's.
module ouvs_cell (
  input  logic                              clk,
  input  ouvs_pkg::ouvs_cell_ctl_t          ctl,
  input  logic signed [ouvs_pkg::VAL_W-1:0] key,
  input  logic signed [ouvs_pkg::VAL_W-1:0] neighbor,
  output logic signed [ouvs_pkg::VAL_W-1:0] entry,
  output logic                              match
);
  import ouvs_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= key;
    end else if (ctl.shift) begin
      entry <= neighbor;
    end
  end

  assign match = ctl.valid && (entry == key);

endmodule

/* rtl/core/ordered_unique_value_set.sv */
// Top level of the ordered unique value set: a chain of compare cells and the result register.
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle while req_stall is low; all cells compare and shift in the same cycle.
// The output register lets a new request in while the previous result is being taken.
// Reset (synchronous, active high) clears the count and the output valid; entries are
// written before they are read and have no reset.
module ordered_unique_value_set (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ouvs_pkg::ouvs_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ouvs_pkg::ouvs_rsp_t rsp
);
  import ouvs_pkg::*;

  logic signed [VAL_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]     match;
  ouvs_cell_ctl_t          ctl [CAPACITY];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [IDX_W-1:0]        hit_idx;
  logic                    hit;
  logic                    full;
  logic                    accept;
  logic                    do_insert;
  logic                    do_remove;
  logic                    rejected;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign hit       = |match;
  assign full      = (count == CNT_W'(CAPACITY));
  assign do_insert = accept && (req.func == FUNC_INSERT) && !hit && !full;
  assign do_remove = accept && (req.func == FUNC_REMOVE) && hit;
  assign rejected  = (req.func == FUNC_INSERT) && !hit && full;

  // Stored values are distinct, so at most one cell matches.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].valid = (CNT_W'(i) < count);
      ctl[i].load  = do_insert && (CNT_W'(i) == count);
      ctl[i].shift = do_remove && (IDX_W'(i) >= hit_idx);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ouvs_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .key      (req.value),
      .neighbor (entry[(g + 1 < CAPACITY) ? g + 1 : g]),
      .entry    (entry[g]),
      .match    (match[g])
    );
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.found         <= hit;
      rsp.position      <= hit ? POS_W'(hit_idx) : '0;
      rsp.entry_count   <= COUNT_W'(count_next);
      rsp.rejected_full <= rejected;
    end
  end

endmodule
